>>> rtl/lu_pkg.sv
// ----------------------------------------------------------------------------
// lu_pkg: shared constants and types for the LU linear system solver
// Fixed-point sizes, store depths and the arithmetic unit command struct.
// ----------------------------------------------------------------------------
package lu_pkg;

  localparam int MAX_EQ      = 8;
  localparam int FRAC_BITS   = 16;
  localparam int IDX_W       = $clog2(MAX_EQ);
  localparam int CNT_W       = $clog2(MAX_EQ + 1);
  localparam int COEF_DEPTH  = MAX_EQ * (MAX_EQ + 1);
  localparam int COEF_AW     = $clog2(COEF_DEPTH);
  localparam int FAC_DEPTH   = MAX_EQ * MAX_EQ;
  localparam int FAC_AW      = $clog2(FAC_DEPTH);
  localparam int VEC_AW      = (IDX_W > 0) ? IDX_W : 1;
  localparam int DIV_W       = 32 + FRAC_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_W + 1);

  localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
  localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

  // Command from sequencer to the shared arithmetic unit
  typedef struct packed {
    logic        clr;      // clear accumulator
    logic        mac;      // accumulate product of a and b
    logic        div_go;   // start (elem - acc) / den
  } alu_cmd_t;

  typedef struct packed {
    logic        div_busy;
    logic        div_zero;
  } alu_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'(Q_MAX)) return 32'h7fffffff;
    if (v < 66'(Q_MIN)) return 32'h80000000;
    return v[31:0];
  endfunction

endpackage

>>> rtl/lu_ram.sv
// ----------------------------------------------------------------------------
// lu_ram: generic single-port-write, single-port-read RAM
// Registered read data.
// ----------------------------------------------------------------------------
module lu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/lu_alu.sv
// ----------------------------------------------------------------------------
// lu_alu: shared multiply-accumulate and restoring divider
// acc += sat(a*b >> F); result = sat(elem - acc); quotient = result / den.
// ----------------------------------------------------------------------------
module lu_alu (
  input  logic                clk,
  input  logic                rst_n,
  input  lu_pkg::alu_cmd_t    cmd,
  input  logic signed [31:0]  a,
  input  logic signed [31:0]  b,
  input  logic signed [31:0]  elem,
  input  logic signed [31:0]  den,
  output logic signed [31:0]  diff,
  output logic signed [31:0]  quot,
  output lu_pkg::alu_stat_t   stat
);

  localparam int DW = lu_pkg::DIV_W;

  logic signed [63:0] prod_r;
  logic               prod_v_r;
  logic signed [37:0] acc_r;           // sum of up to 8 saturated products
  logic signed [63:0] shf;
  logic signed [65:0] dwide;

  // multiply stage, registered before accumulation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= cmd.mac;
    end
    prod_r <= 64'(a) * 64'(b);
  end

  assign shf = prod_r >>> lu_pkg::FRAC_BITS;

  always_ff @(posedge clk) begin
    if (cmd.clr) acc_r <= '0;
    else if (prod_v_r) acc_r <= acc_r + 38'(lu_pkg::sat32(66'(shf)));
  end

  assign dwide = 66'(elem) - 66'(acc_r);
  assign diff  = lu_pkg::sat32(dwide);

  // restoring divider, one bit per cycle
  logic [DW-1:0]               rem_r, dvd_r;
  logic [31:0]                 dvs_r;
  logic                        neg_r, busy_r, zero_r;
  logic [lu_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [DW:0]                 trial;
  logic [31:0]                 un, ud;

  assign un    = diff[31] ? 32'(-diff) : diff;
  assign ud    = den[31]  ? 32'(-den)  : den;
  assign trial = {rem_r, dvd_r[DW-1]} - {(DW+1-32)'(0), dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      zero_r <= 1'b0;
    end else if (cmd.div_go) begin
      zero_r <= (den == 0);
      busy_r <= (den != 0);
      cnt_r  <= lu_pkg::DIV_CNT_W'(DW);
      rem_r  <= '0;
      dvd_r  <= {un, {lu_pkg::FRAC_BITS{1'b0}}};
      dvs_r  <= ud;
      neg_r  <= diff[31] ^ den[31];
    end else if (busy_r) begin
      if (!trial[DW]) rem_r <= trial[DW-1:0];
      else rem_r <= {rem_r[DW-2:0], dvd_r[DW-1]};
      dvd_r <= {dvd_r[DW-2:0], ~trial[DW]};
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == 1) busy_r <= 1'b0;
    end
  end

  // quotient held in dvd_r after the last step
  always_comb begin
    logic [DW:0] q;
    q = {1'b0, dvd_r};
    if (zero_r) quot = '0;
    else if (neg_r) quot = (q > (DW+1)'(33'h080000000)) ? 32'h80000000 : 32'(-q);
    else quot = (q > (DW+1)'(32'h7fffffff)) ? 32'h7fffffff : q[31:0];
  end

  assign stat.div_busy = busy_r;
  assign stat.div_zero = zero_r;

endmodule

>>> rtl/lu_linear_system_solver.sv
// ----------------------------------------------------------------------------
// lu_linear_system_solver: Doolittle LU solve of an n x (n+1) Q16.16 system
// Loads one element per cycle while not busy; after the last element the
// sequencer runs all MACs and divisions on one shared unit, then emits x one
// beat at a time. busy is high from the last element until the final result
// beat. Synchronous active-low reset clears control state; stores are not
// cleared.
// ----------------------------------------------------------------------------
module lu_linear_system_solver (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_matrix_element,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_wdata,
  output logic               out_valid,
  output logic signed [31:0] out_solution_value,
  output logic [2:0]         out_solution_index,
  output logic               out_last_of_run,
  output logic               out_singular
);

  localparam int IW = lu_pkg::IDX_W;
  localparam int CW = lu_pkg::CNT_W;
  localparam int CA = lu_pkg::COEF_AW;
  localparam int FA = lu_pkg::FAC_AW;
  localparam int VA = lu_pkg::VEC_AW;

  // phases
  localparam logic [3:0] S_LOAD = 4'd0, S_ELEM = 4'd1, S_MA = 4'd2, S_MB = 4'd3,
                         S_MW = 4'd4, S_FIN = 4'd5, S_DIV = 4'd6, S_WR = 4'd7,
                         S_NEXT = 4'd8, S_OUT = 4'd9, S_OUTW = 4'd10;
  // passes
  localparam logic [1:0] P_U = 2'd0, P_L = 2'd1, P_F = 2'd2, P_B = 2'd3;

  logic [3:0]  cnt_cfg_r;
  logic [6:0]  lpos_r;
  logic [CW-1:0] n;
  logic [6:0]  total;

  always_comb begin
    if (cnt_cfg_r == 0) n = CW'(1);
    else if (cnt_cfg_r > 4'(lu_pkg::MAX_EQ)) n = CW'(lu_pkg::MAX_EQ);
    else n = CW'(cnt_cfg_r);
  end
  assign total = 7'(n) * (7'(n) + 7'd1);

  logic [3:0]    st_r;
  logic [1:0]    ps_r;
  logic [CW-1:0] k_r, i_r, s_r, lim_r;   // outer, row/col, inner, inner limit
  logic          sing_r;
  logic [IW-1:0] oi_r;

  // stores
  logic          c_we, f_we, y_we, x_we;
  logic [CA-1:0] c_ra;
  logic [FA-1:0] f_ra;
  logic [VA-1:0] v_ra;
  logic [31:0]   c_rd, f_rd, y_rd, x_rd, wres;
  logic [FA-1:0] f_wa;
  logic [VA-1:0] v_wa;

  lu_ram #(.WIDTH(32), .DEPTH(lu_pkg::COEF_DEPTH)) u_coef (
    .clk, .we(c_we), .waddr(lpos_r[CA-1:0]), .wdata(in_matrix_element),
    .raddr(c_ra), .rdata(c_rd));
  lu_ram #(.WIDTH(32), .DEPTH(lu_pkg::FAC_DEPTH)) u_fac (
    .clk, .we(f_we), .waddr(f_wa), .wdata(wres), .raddr(f_ra), .rdata(f_rd));
  lu_ram #(.WIDTH(32), .DEPTH(lu_pkg::MAX_EQ)) u_y (
    .clk, .we(y_we), .waddr(v_wa), .wdata(wres), .raddr(v_ra), .rdata(y_rd));
  lu_ram #(.WIDTH(32), .DEPTH(lu_pkg::MAX_EQ)) u_x (
    .clk, .we(x_we), .waddr(v_wa), .wdata(wres), .raddr(v_ra), .rdata(x_rd));

  function automatic logic [FA-1:0] fidx(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return FA'(r[IW-1:0] * lu_pkg::MAX_EQ + c[IW-1:0]);
  endfunction

  // shared unit operands
  logic signed [31:0] a_r, b_r, elem_r, den_r, diff, quot;
  logic signed [31:0] mul_b;
  lu_pkg::alu_cmd_t   cmd;
  lu_pkg::alu_stat_t  stat;

  // factor-by-factor terms take the second operand straight from the store
  assign mul_b = ((ps_r == P_U) || (ps_r == P_L)) ? f_rd : b_r;

  lu_alu u_alu (.clk, .rst_n, .cmd, .a(a_r), .b(mul_b), .elem(elem_r), .den(den_r),
                .diff, .quot, .stat);

  // read addressing: coefficient element, factor operands per pass
  // row/col meaning: P_U: U[k][i]; P_L: L[i][k]; P_F: y[i]; P_B: x[i]
  always_comb begin
    c_ra = '0; f_ra = '0; v_ra = '0;
    unique case (ps_r)
      P_U: c_ra = CA'(7'(k_r) * (7'(n) + 7'd1) + 7'(i_r));
      P_L: c_ra = CA'(7'(i_r) * (7'(n) + 7'd1) + 7'(k_r));
      P_F: c_ra = CA'(7'(i_r) * (7'(n) + 7'd1) + 7'(n));
      P_B: c_ra = '0;
    endcase
    if (st_r == S_MA) begin
      unique case (ps_r)
        P_U: f_ra = fidx(k_r, s_r);
        P_L: f_ra = fidx(i_r, s_r);
        P_F: begin f_ra = fidx(i_r, s_r); v_ra = VA'(s_r); end
        P_B: begin f_ra = fidx(i_r, s_r); v_ra = VA'(s_r); end
      endcase
    end else if (st_r == S_MB) begin
      unique case (ps_r)
        P_U: f_ra = fidx(s_r, i_r);
        P_L: f_ra = fidx(s_r, k_r);
        default: f_ra = '0;
      endcase
    end else if ((st_r == S_ELEM) || (st_r == S_MW)) begin
      // y[i] must be on the read port when S_FIN captures it
      v_ra = VA'(i_r);
    end else if (st_r == S_FIN) begin
      f_ra = (ps_r == P_L) ? fidx(k_r, k_r) : fidx(i_r, i_r);
      v_ra = VA'(i_r);
    end else if (st_r == S_OUT) begin
      v_ra = VA'(oi_r);
    end
  end

  assign wres = ((ps_r == P_L) || (ps_r == P_B)) ? quot : diff;
  assign f_wa = (ps_r == P_U) ? fidx(k_r, i_r) : fidx(i_r, k_r);
  assign v_wa = VA'(i_r);
  assign c_we = (st_r == S_LOAD) && start && !cfg_we;
  assign f_we = (st_r == S_WR) && ((ps_r == P_U) || (ps_r == P_L));
  assign y_we = (st_r == S_WR) && (ps_r == P_F);
  assign x_we = (st_r == S_WR) && (ps_r == P_B);

  // divider starts once den_r holds the pivot
  always_comb begin
    cmd.clr    = (st_r == S_ELEM);
    cmd.mac    = (st_r == S_MW);
    cmd.div_go = (st_r == S_DIV) && ((ps_r == P_L) || (ps_r == P_B)) && !stat.div_busy
                 && (s_r == CW'(1));
  end

  logic [CW-1:0] lo_first;  // first inner index per pass
  always_comb begin
    unique case (ps_r)
      P_B:     lo_first = i_r + 1'b1;
      default: lo_first = '0;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD; lpos_r <= '0; cnt_cfg_r <= 4'd8; sing_r <= 1'b0;
      ps_r <= P_U; out_valid <= 1'b0;
    end else begin
      out_valid <= (st_r == S_OUTW);
      unique case (st_r)
        S_LOAD: begin
          if (cfg_we) begin
            cnt_cfg_r <= cfg_wdata; lpos_r <= '0; sing_r <= 1'b0;
          end else if (start) begin
            if (lpos_r + 7'd1 >= total) begin
              lpos_r <= '0; sing_r <= 1'b0;
              ps_r <= P_U; k_r <= '0; i_r <= '0; lim_r <= '0; st_r <= S_ELEM;
            end else begin
              lpos_r <= lpos_r + 7'd1;
            end
          end
        end
        S_ELEM: begin
          // element read issued via c_ra, inner loop next
          s_r <= lo_first;
          st_r <= (lo_first < lim_r) ? S_MA : S_FIN;
        end
        S_MA: begin
          st_r <= S_MB;
        end
        S_MB: begin
          a_r <= f_rd;
          if (ps_r == P_F) b_r <= y_rd;
          else if (ps_r == P_B) b_r <= x_rd;
          st_r <= S_MW;
        end
        S_MW: begin
          s_r <= s_r + 1'b1;
          st_r <= (s_r + 1'b1 < lim_r) ? S_MA : S_FIN;
        end
        S_FIN: begin
          // wait for last product to land in acc, capture the element; the pivot follows in S_DIV
          elem_r <= (ps_r == P_B) ? y_rd : c_rd;
          s_r <= '0;
          st_r <= S_DIV;
        end
        S_DIV: begin
          if ((ps_r == P_L) || (ps_r == P_B)) begin
            if (s_r == '0) begin
              den_r <= f_rd; s_r <= CW'(1);
            end else if (s_r == CW'(1)) begin
              s_r <= CW'(2);
            end else if (!stat.div_busy) begin
              st_r <= S_WR;
            end
          end else begin
            st_r <= S_WR;
          end
        end
        S_WR: begin
          if (((ps_r == P_L) || (ps_r == P_B)) && stat.div_zero) sing_r <= 1'b1;
          st_r <= S_NEXT;
        end
        S_NEXT: begin
          st_r <= ((ps_r == P_B) && (i_r == '0)) ? S_OUT : S_ELEM;
          unique case (ps_r)
            P_U: begin
              if (i_r + 1'b1 < n) i_r <= i_r + 1'b1;
              else if (k_r + 1'b1 < n) begin ps_r <= P_L; i_r <= k_r + 1'b1; end
              else begin ps_r <= P_F; i_r <= '0; lim_r <= '0; end
            end
            P_L: begin
              if (i_r + 1'b1 < n) i_r <= i_r + 1'b1;
              else begin
                ps_r <= P_U; k_r <= k_r + 1'b1; i_r <= k_r + 1'b1; lim_r <= k_r + 1'b1;
              end
            end
            P_F: begin
              if (i_r + 1'b1 < n) begin i_r <= i_r + 1'b1; lim_r <= i_r + 1'b1; end
              else begin ps_r <= P_B; i_r <= n - 1'b1; lim_r <= n; end
            end
            P_B: begin
              if (i_r != '0) i_r <= i_r - 1'b1;
              else oi_r <= '0;
            end
          endcase
        end
        S_OUT: begin
          st_r <= S_OUTW;
        end
        S_OUTW: begin
          out_solution_value <= x_rd;
          out_solution_index <= 3'(oi_r);
          out_last_of_run <= (CW'(oi_r) == n - 1'b1);
          out_singular <= sing_r;
          if (CW'(oi_r) == n - 1'b1) st_r <= S_LOAD;
          else begin oi_r <= oi_r + 1'b1; st_r <= S_OUT; end
        end
        default: st_r <= S_LOAD;
      endcase
    end
  end

  assign busy = (st_r != S_LOAD);

  // assertions
  a_no_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy || out_last_of_run) else $error("result while loading");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_of_run) |-> !busy) else $error("run not closed");
  a_no_store_busy: assert property (@(posedge clk) disable iff (!rst_n)
    c_we |-> !busy) else $error("load while solving");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_busy |-> (st_r == S_DIV)) else $error("divider outside divide");

endmodule

>>> sim/lu_solve_checker.sv
// ----------------------------------------------------------------------------
// lu_solve_checker: scoreboard for the LU linear system solver
// Watches the load, config and result beats, predicts the solution vector of
// every completed (A | b) with a Doolittle factorization in Q16.16, and
// compares each result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lu_solve_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] in_matrix_element,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_wdata,
  input  logic               out_valid,
  input  logic signed [31:0] out_solution_value,
  input  logic [2:0]         out_solution_index,
  input  logic               out_last_of_run,
  input  logic               out_singular,
  output int                 error_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ME = lu_pkg::MAX_EQ;

  typedef struct {
    logic signed [31:0] value;
    logic [2:0]         index;
    logic               last;
    logic               singular;
  } solution_t;

  solution_t    solution_q[$];
  int           matrix_mem[lu_pkg::COEF_DEPTH];
  int           lu_mem[lu_pkg::FAC_DEPTH];
  int           y_vec[ME];
  int           x_vec[ME];
  int           load_pos;
  logic [3:0]   eq_count;
  bit           zero_pivot;

  assign pending = solution_q.size();

  function automatic int sat_q(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  // product floored to the Q grid, then saturated
  function automatic longint mul_q(int a, int b);
    longint p;
    p = longint'(a) * longint'(b);
    return longint'(sat_q(p >>> lu_pkg::FRAC_BITS));
  endfunction

  // quotient truncated toward zero; zero divisor yields 0 and flags it
  function automatic int div_q(int num, int den, inout bit zflag);
    longint un, ud, q;
    bit neg;
    if (den == 0) begin
      zflag = 1'b1;
      return 0;
    end
    un  = (num < 0) ? -longint'(num) : longint'(num);
    ud  = (den < 0) ? -longint'(den) : longint'(den);
    neg = (num < 0) != (den < 0);
    q   = (un << lu_pkg::FRAC_BITS) / ud;
    if (neg) begin
      if (q > 64'sd2147483648) return 32'sh80000000;
      return sat_q(-q);
    end
    if (q > 64'sd2147483647) return 32'sh7fffffff;
    return int'(q);
  endfunction

  function automatic int active_n();
    if (eq_count == 0) return 1;
    if (eq_count > ME) return ME;
    return int'(eq_count);
  endfunction

  // factor, substitute both ways and queue the n solution beats
  task automatic solve_system(int n);
    longint acc;
    solution_t s;
    zero_pivot = 1'b0;
    for (int k = 0; k < n; k++) begin
      for (int j = k; j < n; j++) begin
        acc = 0;
        for (int m = 0; m < k; m++) acc += mul_q(lu_mem[k*ME+m], lu_mem[m*ME+j]);
        lu_mem[k*ME+j] = sat_q(longint'(matrix_mem[k*(n+1)+j]) - acc);
      end
      for (int i = k + 1; i < n; i++) begin
        acc = 0;
        for (int m = 0; m < k; m++) acc += mul_q(lu_mem[i*ME+m], lu_mem[m*ME+k]);
        lu_mem[i*ME+k] = div_q(sat_q(longint'(matrix_mem[i*(n+1)+k]) - acc),
                               lu_mem[k*ME+k], zero_pivot);
      end
    end
    for (int i = 0; i < n; i++) begin
      acc = 0;
      for (int j = 0; j < i; j++) acc += mul_q(lu_mem[i*ME+j], y_vec[j]);
      y_vec[i] = sat_q(longint'(matrix_mem[i*(n+1)+n]) - acc);
    end
    for (int i = n - 1; i >= 0; i--) begin
      acc = 0;
      for (int j = i + 1; j < n; j++) acc += mul_q(lu_mem[i*ME+j], x_vec[j]);
      x_vec[i] = div_q(sat_q(longint'(y_vec[i]) - acc), lu_mem[i*ME+i], zero_pivot);
    end
    for (int i = 0; i < n; i++) begin
      s.value    = x_vec[i];
      s.index    = 3'(i);
      s.last     = (i == n - 1);
      s.singular = zero_pivot;
      solution_q.push_back(s);
    end
  endtask

  // config, load and result beats, all sampled at the rising edge
  always @(posedge clk) begin
    int n;
    solution_t e;
    if (!rst_n) begin
      load_pos    <= 0;
      eq_count    <= 4'd8;
      zero_pivot  = 1'b0;
      error_count <= 0;
    end else begin
      if (out_valid) begin
        if (solution_q.size() == 0) begin
          $display("%0t: unexpected result beat value=%0d index=%0d", $time,
                   out_solution_value, out_solution_index);
          error_count <= error_count + 1;
        end else begin
          e = solution_q.pop_front();
          if (out_solution_value !== e.value || out_solution_index !== e.index ||
              out_last_of_run !== e.last || out_singular !== e.singular) begin
            $display("%0t: mismatch exp value=%0d idx=%0d last=%0b sing=%0b",
                     $time, e.value, e.index, e.last, e.singular);
            $display("%0t:          act value=%0d idx=%0d last=%0b sing=%0b",
                     $time, out_solution_value, out_solution_index,
                     out_last_of_run, out_singular);
            error_count <= error_count + 1;
          end
        end
      end
      if (cfg_we) begin
        eq_count   <= cfg_wdata;
        load_pos   <= 0;
        zero_pivot = 1'b0;
      end else if (start && !busy) begin
        n = active_n();
        matrix_mem[load_pos] = in_matrix_element;
        if (load_pos + 1 >= n * (n + 1)) begin
          load_pos <= 0;
          solve_system(n);
        end else begin
          load_pos <= load_pos + 1;
        end
      end
    end
  end

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the LU linear system solver
// Loads directed and random augmented matrices over several equation counts,
// with random sender gaps; the checker predicts and compares every beat.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [31:0] in_matrix_element;
  logic               cfg_we;
  logic [3:0]         cfg_wdata;
  logic               out_valid;
  logic signed [31:0] out_solution_value;
  logic [2:0]         out_solution_index;
  logic               out_last_of_run;
  logic               out_singular;
  int                 error_count;
  int                 pending;

  int                 elems_sent;
  int                 cur_n;
  bit                 no_gaps;

  lu_linear_system_solver uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_matrix_element  (in_matrix_element),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_solution_value (out_solution_value),
    .out_solution_index (out_solution_index),
    .out_last_of_run    (out_last_of_run),
    .out_singular       (out_singular)
  );

  lu_solve_checker chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_matrix_element  (in_matrix_element),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_solution_value (out_solution_value),
    .out_solution_index (out_solution_index),
    .out_last_of_run    (out_last_of_run),
    .out_singular       (out_singular),
    .error_count        (error_count),
    .pending            (pending)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // one load beat; start stays high across back-to-back beats
  task automatic send_elem(int v);
    int gap;
    while (busy) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start             <= 1'b1;
    in_matrix_element <= v;
    @(negedge clk);
    elems_sent++;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // wait for every solution beat, let the block settle, then write n
  task automatic write_count(logic [3:0] v);
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_n = (v == 0) ? 1 : ((v > lu_pkg::MAX_EQ) ? lu_pkg::MAX_EQ : int'(v));
  endtask

  // kind 0: large diagonal (|d| >= 1, others |v| <= 1), 1: raw 32-bit, 2: zero leading pivot
  task automatic send_matrix(int kind);
    int v;
    for (int r = 0; r < cur_n; r++) begin
      for (int c = 0; c <= cur_n; c++) begin
        if (kind == 1) v = $urandom;
        else if (c == cur_n) v = $urandom_range(0, 32'h3fffff) - 32'h200000;
        else if (r == c) begin
          v = ($urandom_range(1, 8) << lu_pkg::FRAC_BITS) + $urandom_range(0, 65535);
          if ($urandom_range(0, 1)) v = -v;
        end else v = $urandom_range(0, 131071) - 65536;
        if (kind == 2 && r == 0 && c == 0) v = 0;
        send_elem(v);
      end
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    start             = 1'b0;
    in_matrix_element = '0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    elems_sent        = 0;
    no_gaps           = 1'b0;
    cur_n             = lu_pkg::MAX_EQ;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: one equation, extreme elements and a zero pivot
    write_count(4'd1);
    send_elem(32'h00010000); send_elem(32'h7fffffff);
    send_elem(32'h00000000); send_elem(32'h00050000);
    send_elem(32'hffffffff); send_elem(32'h80000000);
    send_elem(32'h80000000); send_elem(32'h7fffffff);
    send_elem(32'h00000001); send_elem(32'h7fffffff);
    // count 0 acts as one equation
    write_count(4'd0);
    send_elem(32'h80000000); send_elem(32'h80000000);
    // partial load abandoned by a count write
    write_count(4'd2);
    send_elem(32'h12345678); send_elem(32'h00010000); send_elem(32'h00020000);
    // above the built size acts as the full size
    write_count(4'd15);
    send_matrix(0);
    write_count(4'd2);
    send_elem(32'h00010000); send_elem(32'h00000000); send_elem(32'h00030000);
    send_elem(32'h00000000); send_elem(32'h00010000); send_elem(32'hfffc0000);

    // random matrices, mostly well formed
    while (elems_sent < 480) begin
      int kind;
      if ($urandom_range(0, 2) == 0) write_count(4'($urandom_range(0, 15)));
      else if ($urandom_range(0, 3) == 0) write_count(4'($urandom_range(1, 3)));
      no_gaps = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      send_matrix(kind < 7 ? 0 : (kind < 9 ? 1 : 2));
    end
    start <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (error_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // generous run limit
  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
